### rtl/lsasc_pkg.sv
// Shared constants for the LED strip splat compositor.
package lsasc_pkg;

   localparam int MAX_LEDS = 512;

   localparam int CH_W = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int OP_W = 2;
   localparam int POS_W = 19;
   localparam int FRAC_W = 8;
   localparam int PIXEL_INDEX_W = 9;
   localparam int LED_COUNT_W = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 10;

   localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CNT_W = $clog2(MAX_LEDS + 1);
   // Whole part of the position plus one bit of headroom for the neighbour.
   localparam int PIDX_W = POS_W - FRAC_W + 1;
   localparam int CMP_W = ((CNT_W > PIDX_W) ? CNT_W : PIDX_W) + 1;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_SPLAT = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_LED_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS = 4'd1;

   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

endpackage

### rtl/lsasc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsasc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lsasc_scale.sv
// Shared scaling unit: registered floor(a * b / 255) on 8-bit operands.
module lsasc_scale
   import lsasc_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [CH_W-1:0] a,
   input  logic [CH_W-1:0] b,
   output logic [CH_W-1:0] q
);

   logic [2*CH_W-1:0] prod;
   logic [2*CH_W:0]   sum;
   logic [CH_W-1:0]   q_ff;

   // Division by 255 as (p + p/256 + 1) / 256, exact for every 8 by 8 product.
   always_comb begin
      prod = a * b;
      sum = {1'b0, prod} + {{(CH_W+1){1'b0}}, prod[2*CH_W-1:CH_W]} + (2*CH_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= sum[2*CH_W-1:CH_W];
      end
   end

   assign q = q_ff;

endmodule

### rtl/led_strip_additive_splat_compositor_unit.sv
// Top level of the LED strip splat compositor: sequencer, frame store and register port.
//
// The block keeps a frame of MAX_LEDS RGB pixels in a single RAM and works on one
// transaction at a time; req_ready is high only while the sequencer is idle. All
// channel weighting goes through one shared 8 by 8 scaling unit, one colour channel
// per cycle. A read fetches the pixel and scales its channels by the brightness
// before the result is offered, or offers zero when the index is beyond the strip;
// a splat reads, weights, adds and writes back each of its two pixels that lies on
// the strip and skips each that does not; and a clear sweeps the RAM at one pixel a
// cycle. After reset the same sweep runs before the first transaction is accepted;
// register writes are taken at any time. A result waiting on the response port does
// not hold back the next transaction, only the completion of a later read.
module led_strip_additive_splat_compositor_unit
   import lsasc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [POS_W-1:0]  req_position,
   input  logic [CH_W-1:0]          req_red_in,
   input  logic [CH_W-1:0]          req_green_in,
   input  logic [CH_W-1:0]          req_blue_in,
   input  logic [PIXEL_INDEX_W-1:0] req_pixel_index,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CH_W-1:0]          rsp_red_out,
   output logic [CH_W-1:0]          rsp_green_out,
   output logic [CH_W-1:0]          rsp_blue_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PIX,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_WRITE,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic                     is_read_ff, is_read_in;
   logic                     zero_ff, zero_in;
   logic                     pix_sel_ff, pix_sel_in;
   logic signed [PIDX_W-1:0] base_idx_ff, base_idx_in;
   logic [CH_W-1:0]          w0_ff, w0_in;
   logic [CH_W-1:0]          w1_ff, w1_in;
   logic [CH_W-1:0]          col_red_ff, col_red_in;
   logic [CH_W-1:0]          col_green_ff, col_green_in;
   logic [CH_W-1:0]          col_blue_ff, col_blue_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [CH_W-1:0]          prod_red_ff, prod_red_in;
   logic [CH_W-1:0]          prod_green_ff, prod_green_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]          rsp_red_ff, rsp_red_in;
   logic [CH_W-1:0]          rsp_green_ff, rsp_green_in;
   logic [CH_W-1:0]          rsp_blue_ff, rsp_blue_in;
   logic [LED_COUNT_W-1:0]   led_count_ff, led_count_in;
   logic [CH_W-1:0]          brightness_ff, brightness_in;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [PIX_W-1:0]         ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [PIX_W-1:0]         ram_rd_data;

   logic                     unit_en;
   logic [CH_W-1:0]          unit_a;
   logic [CH_W-1:0]          unit_b;
   logic [CH_W-1:0]          unit_q;

   logic                     req_fire;
   logic [CMP_W-1:0]         active_count;
   logic signed [PIDX_W-1:0] pix_idx;
   logic                     pix_on_strip;
   logic                     read_on_strip;
   logic [2*CH_W-1:0]        frac_prod;
   logic [2*CH_W-1:0]        rest_prod;
   logic [CH_W:0]            sum_red;
   logic [CH_W:0]            sum_green;
   logic [CH_W:0]            sum_blue;
   logic [CH_W-1:0]          new_red;
   logic [CH_W-1:0]          new_green;
   logic [CH_W-1:0]          new_blue;

   lsasc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (1 << ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lsasc_scale u_scale (
      .clock (clock),
      .en    (unit_en),
      .a     (unit_a),
      .b     (unit_b),
      .q     (unit_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_out = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out = rsp_blue_ff;

   always_comb begin
      active_count = (CMP_W'(led_count_ff) > CMP_W'(MAX_LEDS)) ?
                     CMP_W'(MAX_LEDS) : CMP_W'(led_count_ff);
      pix_idx = pix_sel_ff ? (base_idx_ff + PIDX_W'(1)) : base_idx_ff;
      pix_on_strip = !pix_idx[PIDX_W-1] && (CMP_W'(unsigned'(pix_idx)) < active_count);
      read_on_strip = CMP_W'(req_pixel_index) < active_count;

      // Weights: w1 = floor(255 f / 256), w0 = floor(255 (256 - f) / 256).
      frac_prod = {req_position[FRAC_W-1:0], {CH_W{1'b0}}} -
                  {{CH_W{1'b0}}, req_position[FRAC_W-1:0]};
      rest_prod = {CH_MAX, {CH_W{1'b0}}} - frac_prod;

      sum_red = {1'b0, ram_rd_data[3*CH_W-1:2*CH_W]} + {1'b0, prod_red_ff};
      sum_green = {1'b0, ram_rd_data[2*CH_W-1:CH_W]} + {1'b0, prod_green_ff};
      sum_blue = {1'b0, ram_rd_data[CH_W-1:0]} + {1'b0, unit_q};
      new_red = sum_red[CH_W] ? CH_MAX : sum_red[CH_W-1:0];
      new_green = sum_green[CH_W] ? CH_MAX : sum_green[CH_W-1:0];
      new_blue = sum_blue[CH_W] ? CH_MAX : sum_blue[CH_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      is_read_in = is_read_ff;
      zero_in = zero_ff;
      pix_sel_in = pix_sel_ff;
      base_idx_in = base_idx_ff;
      w0_in = w0_ff;
      w1_in = w1_ff;
      col_red_in = col_red_ff;
      col_green_in = col_green_ff;
      col_blue_in = col_blue_ff;
      addr_in = addr_ff;
      prod_red_in = prod_red_ff;
      prod_green_in = prod_green_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_red_in = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in = rsp_blue_ff;
      led_count_in = led_count_ff;
      brightness_in = brightness_ff;

      ram_wr_en = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = {new_red, new_green, new_blue};
      ram_rd_en = 1'b0;
      ram_rd_addr = ADDR_W'(unsigned'(pix_idx));

      unit_en = 1'b0;
      unit_a = col_red_ff;
      unit_b = pix_sel_ff ? w1_ff : w0_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LED_COUNT: led_count_in = csr_data[LED_COUNT_W-1:0];
            REG_BRIGHTNESS: brightness_in = csr_data[CH_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_LEDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               // The whole part is signed, so it is sign extended into the index.
               base_idx_in = {req_position[POS_W-1], req_position[POS_W-1:FRAC_W]};
               w0_in = rest_prod[2*CH_W-1:CH_W];
               w1_in = frac_prod[2*CH_W-1:CH_W];
               col_red_in = req_red_in;
               col_green_in = req_green_in;
               col_blue_in = req_blue_in;
               pix_sel_in = 1'b0;
               case (req_op)
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in = S_CLEAR;
                  end
                  OP_SPLAT: begin
                     is_read_in = 1'b0;
                     state_in = S_PIX;
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                     if (read_on_strip) begin
                        zero_in = 1'b0;
                        ram_rd_en = 1'b1;
                        ram_rd_addr = ADDR_W'(req_pixel_index);
                        state_in = S_MUL0;
                     end else begin
                        zero_in = 1'b1;
                        state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PIX: begin
            if (pix_on_strip) begin
               ram_rd_en = 1'b1;
               addr_in = ADDR_W'(unsigned'(pix_idx));
               state_in = S_MUL0;
            end else if (!pix_sel_ff) begin
               pix_sel_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL0: begin
            unit_en = 1'b1;
            unit_a = is_read_ff ? ram_rd_data[3*CH_W-1:2*CH_W] : col_red_ff;
            unit_b = is_read_ff ? brightness_ff : (pix_sel_ff ? w1_ff : w0_ff);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            unit_en = 1'b1;
            unit_a = is_read_ff ? ram_rd_data[2*CH_W-1:CH_W] : col_green_ff;
            unit_b = is_read_ff ? brightness_ff : (pix_sel_ff ? w1_ff : w0_ff);
            prod_red_in = unit_q;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            unit_en = 1'b1;
            unit_a = is_read_ff ? ram_rd_data[CH_W-1:0] : col_blue_ff;
            unit_b = is_read_ff ? brightness_ff : (pix_sel_ff ? w1_ff : w0_ff);
            prod_green_in = unit_q;
            state_in = is_read_ff ? S_OUT : S_WRITE;
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if (!pix_sel_ff) begin
               pix_sel_in = 1'b1;
               state_in = S_PIX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            // The response register must be free, or emptied in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_red_in = zero_ff ? '0 : prod_red_ff;
               rsp_green_in = zero_ff ? '0 : prod_green_ff;
               rsp_blue_in = zero_ff ? '0 : unit_q;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         led_count_ff <= '0;
         brightness_ff <= CH_MAX;
         is_read_ff <= 1'b0;
         zero_ff <= 1'b0;
         pix_sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         led_count_ff <= led_count_in;
         brightness_ff <= brightness_in;
         is_read_ff <= is_read_in;
         zero_ff <= zero_in;
         pix_sel_ff <= pix_sel_in;
      end
      base_idx_ff <= base_idx_in;
      w0_ff <= w0_in;
      w1_ff <= w1_in;
      col_red_ff <= col_red_in;
      col_green_ff <= col_green_in;
      col_blue_ff <= col_blue_in;
      addr_ff <= addr_in;
      prod_red_ff <= prod_red_in;
      prod_green_ff <= prod_green_in;
      rsp_red_ff <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff <= rsp_blue_in;
   end

endmodule

### rtl/lsasc_checker.sv
// Port-level checker for the splat compositor, bound to the top level.
module lsasc_checker
   import lsasc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [OP_W-1:0]          req_op,
   input logic signed [POS_W-1:0]  req_position,
   input logic [CH_W-1:0]          req_red_in,
   input logic [CH_W-1:0]          req_green_in,
   input logic [CH_W-1:0]          req_blue_in,
   input logic [PIXEL_INDEX_W-1:0] req_pixel_index,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CH_W-1:0]          rsp_red_out,
   input logic [CH_W-1:0]          rsp_green_out,
   input logic [CH_W-1:0]          rsp_blue_out,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [CSR_INDEX_W-1:0]   csr_index,
   input logic [CSR_DATA_W-1:0]    csr_data
);

   // A stalled result holds its value until the transaction completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out) &&
      $stable(rsp_green_out) && $stable(rsp_blue_out))
      else $error("response changed while stalled");

   // Every accepted clear or read keeps the sequencer busy in the next cycle.
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_CLEAR || req_op == OP_READ) |=> !req_ready)
      else $error("ready returned straight after a clear or read");

   // Only reads produce results: other operations leave an empty response port empty.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op != OP_READ && !rsp_valid |=> !rsp_valid)
      else $error("result appeared for an operation that has none");

   // A new result is only ever posted while no transaction can be accepted.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result posted while the sequencer was idle");

endmodule

bind led_strip_additive_splat_compositor_unit lsasc_checker u_checker (.*);
